// ----- hw/rtl/line_edit_buffer_assert.svh -----
// Assertion macros for the line edit buffer checker.
`ifndef LINE_EDIT_BUFFER_ASSERT_SVH
`define LINE_EDIT_BUFFER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LEB_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line_edit_buffer: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LEB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line_edit_buffer: next-cycle check failed");

`endif

// ----- hw/rtl/leb_pkg.sv -----
// Package with the types, codes and constants of the line edit buffer.
package leb_pkg;

   // Default line capacity in characters.
   localparam int LEB_LINE_CAPACITY = 64;

   // Fixed field widths on the ports.
   localparam int KEY_W     = 8;
   localparam int POS_W     = 7;
   localparam int OUTCOME_W = 2;
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_KEY_LEFT      = 3'd0;
   localparam logic [2:0] REG_KEY_RIGHT     = 3'd1;
   localparam logic [2:0] REG_KEY_UP        = 3'd2;
   localparam logic [2:0] REG_KEY_DOWN      = 3'd3;
   localparam logic [2:0] REG_KEY_BACKSPACE = 3'd4;
   localparam logic [2:0] REG_KEY_DELETE    = 3'd5;
   localparam logic [2:0] REG_KEY_RETURN    = 3'd6;

   // Reset values of the key map.
   localparam logic [KEY_W-1:0] RST_KEY_LEFT      = 8'd28;
   localparam logic [KEY_W-1:0] RST_KEY_RIGHT     = 8'd29;
   localparam logic [KEY_W-1:0] RST_KEY_UP        = 8'd30;
   localparam logic [KEY_W-1:0] RST_KEY_DOWN      = 8'd31;
   localparam logic [KEY_W-1:0] RST_KEY_BACKSPACE = 8'd8;
   localparam logic [KEY_W-1:0] RST_KEY_DELETE    = 8'd127;
   localparam logic [KEY_W-1:0] RST_KEY_RETURN    = 8'd13;

   // Outcome codes of a result word.
   localparam logic [OUTCOME_W-1:0] OUTCOME_APPLIED   = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_NO_EFFECT = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_FULL      = 2'd2;
   localparam logic [OUTCOME_W-1:0] OUTCOME_LINE      = 2'd3;

   // What a key code means under the current key map.
   typedef enum logic [2:0] {
      KEY_RIGHT,
      KEY_LEFT,
      KEY_IGNORE,
      KEY_BACK,
      KEY_DEL,
      KEY_RET,
      KEY_INS
   } key_class_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOVE,
      ST_EMIT_RD,
      ST_EMIT_LD
   } seq_state_type;

endpackage

// ----- hw/rtl/leb_req_if.sv -----
// Key code channel interface.
interface leb_req_if
   import leb_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] key_code;

   modport source (output valid, output key_code, input ready);
   modport sink (input valid, input key_code, output ready);
endinterface

// ----- hw/rtl/leb_rsp_if.sv -----
// Result channel interface.
interface leb_rsp_if
   import leb_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [POS_W-1:0]     cursor_now;
   logic [POS_W-1:0]     length_now;
   logic [OUTCOME_W-1:0] outcome;
   logic [KEY_W-1:0]     line_char;
   logic                 char_valid;
   logic                 last_of_run;

   modport source (output valid, output cursor_now, output length_now, output outcome,
                   output line_char, output char_valid, output last_of_run, input ready);
   modport sink (input valid, input cursor_now, input length_now, input outcome,
                 input line_char, input char_valid, input last_of_run, output ready);
endinterface

// ----- hw/rtl/leb_csr.sv -----
// Key map registers on the APB-style port and the key code classifier.
module leb_csr
   import leb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   input  logic [KEY_W-1:0]  key_code,
   output key_class_type     key_class
);

   logic [KEY_W-1:0] left_ff, right_ff, up_ff, down_ff;
   logic [KEY_W-1:0] back_ff, del_ff, ret_ff;
   logic [2:0]       reg_index;
   logic             wr_fire;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];
   assign wr_fire   = psel && penable && pwrite;

   // Key map registers, written on the access cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= RST_KEY_LEFT;
         right_ff <= RST_KEY_RIGHT;
         up_ff    <= RST_KEY_UP;
         down_ff  <= RST_KEY_DOWN;
         back_ff  <= RST_KEY_BACKSPACE;
         del_ff   <= RST_KEY_DELETE;
         ret_ff   <= RST_KEY_RETURN;
      end else if (wr_fire) begin
         unique case (reg_index)
            REG_KEY_LEFT:      left_ff  <= pwdata[KEY_W-1:0];
            REG_KEY_RIGHT:     right_ff <= pwdata[KEY_W-1:0];
            REG_KEY_UP:        up_ff    <= pwdata[KEY_W-1:0];
            REG_KEY_DOWN:      down_ff  <= pwdata[KEY_W-1:0];
            REG_KEY_BACKSPACE: back_ff  <= pwdata[KEY_W-1:0];
            REG_KEY_DELETE:    del_ff   <= pwdata[KEY_W-1:0];
            REG_KEY_RETURN:    ret_ff   <= pwdata[KEY_W-1:0];
            default: ;
         endcase
      end
   end

   // Read mux; an address past the map reads as zero.
   always_comb begin
      prdata = '0;
      unique case (reg_index)
         REG_KEY_LEFT:      prdata[KEY_W-1:0] = left_ff;
         REG_KEY_RIGHT:     prdata[KEY_W-1:0] = right_ff;
         REG_KEY_UP:        prdata[KEY_W-1:0] = up_ff;
         REG_KEY_DOWN:      prdata[KEY_W-1:0] = down_ff;
         REG_KEY_BACKSPACE: prdata[KEY_W-1:0] = back_ff;
         REG_KEY_DELETE:    prdata[KEY_W-1:0] = del_ff;
         REG_KEY_RETURN:    prdata[KEY_W-1:0] = ret_ff;
         default: ;
      endcase
   end

   // Classify the key; the first match wins when codes coincide.
   always_comb begin
      priority if (key_code == right_ff) begin
         key_class = KEY_RIGHT;
      end else if (key_code == left_ff) begin
         key_class = KEY_LEFT;
      end else if (key_code == up_ff || key_code == down_ff) begin
         key_class = KEY_IGNORE;
      end else if (key_code == back_ff) begin
         key_class = KEY_BACK;
      end else if (key_code == del_ff) begin
         key_class = KEY_DEL;
      end else if (key_code == ret_ff) begin
         key_class = KEY_RET;
      end else begin
         key_class = KEY_INS;
      end
   end

endmodule

// ----- hw/rtl/leb_store.sv -----
// Line character memory: one write port and one registered read port.
module leb_store
   import leb_pkg::*;
#(
   parameter int LINE_CAPACITY = LEB_LINE_CAPACITY,
   localparam int AW = $clog2(LINE_CAPACITY)
)(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [KEY_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [KEY_W-1:0] rd_data
);

   logic [KEY_W-1:0] mem [LINE_CAPACITY];
   logic [KEY_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds between reads.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/leb_seq.sv -----
// Edit sequencer: cursor and length, tail shifts through the memory, line readout.
module leb_seq
   import leb_pkg::*;
#(
   parameter int LINE_CAPACITY = LEB_LINE_CAPACITY,
   localparam int AW = $clog2(LINE_CAPACITY),
   localparam int CW = $clog2(LINE_CAPACITY + 1)
)(
   input  logic             clock,
   input  logic             reset,
   leb_req_if.sink          req,
   leb_rsp_if.source        rsp,
   input  key_class_type    key_class,
   output logic             wr_en,
   output logic [AW-1:0]    wr_addr,
   output logic [KEY_W-1:0] wr_data,
   output logic             rd_en,
   output logic [AW-1:0]    rd_addr,
   input  logic [KEY_W-1:0] rd_data
);

   seq_state_type        state_ff, state_in;
   logic [CW-1:0]        cursor_ff, cursor_in;
   logic [CW-1:0]        length_ff, length_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic                 ins_ff, ins_in;
   logic                 up_ff, up_in;
   logic [AW-1:0]        src_ff, src_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 pend_ff, pend_in;
   logic [AW-1:0]        pend_addr_ff, pend_addr_in;
   logic                 out_valid_ff, out_valid_in;
   logic [POS_W-1:0]     out_cursor_ff, out_cursor_in;
   logic [POS_W-1:0]     out_length_ff, out_length_in;
   logic [OUTCOME_W-1:0] out_outcome_ff, out_outcome_in;
   logic [KEY_W-1:0]     out_char_ff, out_char_in;
   logic                 out_cvalid_ff, out_cvalid_in;
   logic                 out_last_ff, out_last_in;
   logic                 accept;
   logic                 rsp_take;

   assign req.ready       = (state_ff == ST_IDLE) && !out_valid_ff;
   assign accept          = req.valid && req.ready;
   assign rsp_take        = out_valid_ff && rsp.ready;
   assign rsp.valid       = out_valid_ff;
   assign rsp.cursor_now  = out_cursor_ff;
   assign rsp.length_now  = out_length_ff;
   assign rsp.outcome     = out_outcome_ff;
   assign rsp.line_char   = out_char_ff;
   assign rsp.char_valid  = out_cvalid_ff;
   assign rsp.last_of_run = out_last_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         length_ff    <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         length_ff    <= length_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Working and result word registers.
   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      ins_ff         <= ins_in;
      up_ff          <= up_in;
      src_ff         <= src_in;
      cnt_ff         <= cnt_in;
      pend_addr_ff   <= pend_addr_in;
      out_cursor_ff  <= out_cursor_in;
      out_length_ff  <= out_length_in;
      out_outcome_ff <= out_outcome_in;
      out_char_ff    <= out_char_in;
      out_cvalid_ff  <= out_cvalid_in;
      out_last_ff    <= out_last_in;
   end

   // Next state, memory port control and result word loading.
   always_comb begin
      logic load;
      load           = 1'b0;
      state_in       = state_ff;
      cursor_in      = cursor_ff;
      length_in      = length_ff;
      key_in         = key_ff;
      ins_in         = ins_ff;
      up_in          = up_ff;
      src_in         = src_ff;
      cnt_in         = cnt_ff;
      pend_in        = pend_ff;
      pend_addr_in   = pend_addr_ff;
      out_outcome_in = out_outcome_ff;
      out_char_in    = out_char_ff;
      out_cvalid_in  = out_cvalid_ff;
      out_last_in    = out_last_ff;
      wr_en          = 1'b0;
      wr_addr        = pend_addr_ff;
      wr_data        = rd_data;
      rd_en          = 1'b0;
      rd_addr        = src_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in         = req.key_code;
               ins_in         = 1'b0;
               out_outcome_in = OUTCOME_APPLIED;
               out_char_in    = '0;
               out_cvalid_in  = 1'b0;
               out_last_in    = 1'b1;
               unique case (key_class)
                  KEY_RIGHT: begin
                     load = 1'b1;
                     if (cursor_ff < length_ff) begin
                        cursor_in = cursor_ff + 1'b1;
                     end else begin
                        out_outcome_in = OUTCOME_NO_EFFECT;
                     end
                  end
                  KEY_LEFT: begin
                     load = 1'b1;
                     if (cursor_ff != '0) begin
                        cursor_in = cursor_ff - 1'b1;
                     end else begin
                        out_outcome_in = OUTCOME_NO_EFFECT;
                     end
                  end
                  KEY_IGNORE: begin
                     load           = 1'b1;
                     out_outcome_in = OUTCOME_NO_EFFECT;
                  end
                  KEY_BACK: begin
                     if (cursor_ff != '0) begin
                        // Pull the tail one place left over the removed character.
                        src_in    = cursor_ff[AW-1:0];
                        cnt_in    = length_ff - cursor_ff;
                        up_in     = 1'b0;
                        cursor_in = cursor_ff - 1'b1;
                        length_in = length_ff - 1'b1;
                        state_in  = ST_MOVE;
                     end else begin
                        load           = 1'b1;
                        out_outcome_in = OUTCOME_NO_EFFECT;
                     end
                  end
                  KEY_DEL: begin
                     if (cursor_ff < length_ff) begin
                        src_in    = AW'(cursor_ff + 1'b1);
                        cnt_in    = length_ff - cursor_ff - 1'b1;
                        up_in     = 1'b0;
                        length_in = length_ff - 1'b1;
                        state_in  = ST_MOVE;
                     end else begin
                        load           = 1'b1;
                        out_outcome_in = OUTCOME_NO_EFFECT;
                     end
                  end
                  KEY_RET: begin
                     cursor_in      = '0;
                     length_in      = '0;
                     out_outcome_in = OUTCOME_LINE;
                     if (length_ff == '0) begin
                        load = 1'b1;
                     end else begin
                        src_in   = '0;
                        cnt_in   = length_ff;
                        state_in = ST_EMIT_RD;
                     end
                  end
                  KEY_INS: begin
                     if (length_ff == CW'(LINE_CAPACITY)) begin
                        load           = 1'b1;
                        out_outcome_in = OUTCOME_FULL;
                     end else begin
                        // Push the tail one place right, last character first.
                        src_in    = AW'(length_ff - 1'b1);
                        cnt_in    = length_ff - cursor_ff;
                        up_in     = 1'b1;
                        ins_in    = 1'b1;
                        cursor_in = cursor_ff + 1'b1;
                        length_in = length_ff + 1'b1;
                        state_in  = ST_MOVE;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_MOVE: begin
            // Write back the character read in the cycle before.
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_addr_ff;
               wr_data = rd_data;
            end
            if (cnt_ff != '0) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               cnt_in  = cnt_ff - 1'b1;
               if (up_ff) begin
                  pend_addr_in = src_ff + 1'b1;
                  src_in       = src_ff - 1'b1;
               end else begin
                  pend_addr_in = src_ff - 1'b1;
                  src_in       = src_ff + 1'b1;
               end
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  // Shift done: drop the new character into the gap.
                  if (ins_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = AW'(cursor_ff - 1'b1);
                     wr_data = key_ff;
                  end
                  load           = 1'b1;
                  out_outcome_in = OUTCOME_APPLIED;
                  state_in       = ST_IDLE;
               end
            end
         end

         ST_EMIT_RD: begin
            // Read the next character once the result register frees up.
            if (!out_valid_ff || rsp.ready) begin
               rd_en    = 1'b1;
               state_in = ST_EMIT_LD;
            end
         end

         ST_EMIT_LD: begin
            load           = 1'b1;
            out_outcome_in = OUTCOME_LINE;
            out_char_in    = rd_data;
            out_cvalid_in  = 1'b1;
            out_last_in    = (cnt_ff == CW'(1));
            cnt_in         = cnt_ff - 1'b1;
            src_in         = src_ff + 1'b1;
            state_in       = (cnt_ff == CW'(1)) ? ST_IDLE : ST_EMIT_RD;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Result register: load a new word or keep the one not yet taken.
      out_valid_in  = load || (out_valid_ff && !rsp_take);
      out_cursor_in = load ? POS_W'(cursor_in) : out_cursor_ff;
      out_length_in = load ? POS_W'(length_in) : out_length_ff;
   end

endmodule

// ----- hw/rtl/line_edit_buffer.sv -----
// Line edit buffer top level: key map registers, edit sequencer and line memory.
//
// One key code word enters on the req channel; results leave on the rsp channel.
// The key map (left, right, up, down, backspace, delete, return) sits on the
// APB-style csr port, one 8-bit register per word address; the user writes it only
// while idle, which the block does not enforce. Every key but return gives one
// result word. Return gives one word per character of the line, in order, the last
// one flagged, and an empty line gives one word. Cursor moves, ignored keys and
// rejected edits answer in the cycle after acceptance. Insert, backspace and
// delete shift the tail through the two-port line memory, one character per cycle.
// Return reads each character via the memory's read register into the result word.
// The block takes a new key word only when idle and its result register is empty.
// Reset clears cursor, length and sequencer and presets the key map; memory keeps
// its contents, and only characters below the line length are ever read.
// When the receiver stalls, the result word holds and the sequencer waits.
module line_edit_buffer
   import leb_pkg::*;
#(
   parameter int LINE_CAPACITY = LEB_LINE_CAPACITY
)(
   input  logic              clock,
   input  logic              reset,
   leb_req_if.sink           req_chan,
   leb_rsp_if.source         rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   localparam int AW = $clog2(LINE_CAPACITY);

   key_class_type    key_class;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [KEY_W-1:0] wr_data;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic [KEY_W-1:0] rd_data;

   // Key map and classifier.
   leb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .key_code  (req_chan.key_code),
      .key_class (key_class)
   );

   // Edit sequencer.
   leb_seq #(.LINE_CAPACITY(LINE_CAPACITY)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .key_class (key_class),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   // Line memory.
   leb_store #(.LINE_CAPACITY(LINE_CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ----- hw/rtl/leb_checker.sv -----
// Port-level checker for the line edit buffer and its bind to the top level.
`include "line_edit_buffer_assert.svh"

module leb_checker
   import leb_pkg::*;
#(
   parameter int LINE_CAPACITY = LEB_LINE_CAPACITY
)(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [POS_W-1:0]     rsp_cursor_now,
   input logic [POS_W-1:0]     rsp_length_now,
   input logic [OUTCOME_W-1:0] rsp_outcome,
   input logic [KEY_W-1:0]     rsp_line_char,
   input logic                 rsp_char_valid,
   input logic                 rsp_last_of_run
);

   // A stalled result word holds.
   `LEB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_line_char) && $stable(rsp_outcome) && $stable(rsp_last_of_run))

   // The cursor never passes the end of the line, nor the line its capacity.
   `LEB_ASSERT_NOW(a_cursor_in_line, clock, reset, rsp_valid, rsp_cursor_now <= rsp_length_now && rsp_length_now <= POS_W'(LINE_CAPACITY))

   // Committed output reports an empty, homed line.
   `LEB_ASSERT_NOW(a_commit_clears, clock, reset, rsp_valid && rsp_outcome == OUTCOME_LINE, rsp_cursor_now == '0 && rsp_length_now == '0)

   // Only committed output carries a character.
   `LEB_ASSERT_NOW(a_char_only_commit, clock, reset, rsp_valid && rsp_char_valid, rsp_outcome == OUTCOME_LINE)

   // A key word is taken only while no result word is pending.
   `LEB_ASSERT_NOW(a_one_at_a_time, clock, reset, req_valid && req_ready, !rsp_valid)

endmodule

bind line_edit_buffer leb_checker #(.LINE_CAPACITY(LINE_CAPACITY)) u_leb_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_cursor_now  (rsp_chan.cursor_now),
   .rsp_length_now  (rsp_chan.length_now),
   .rsp_outcome     (rsp_chan.outcome),
   .rsp_line_char   (rsp_chan.line_char),
   .rsp_char_valid  (rsp_chan.char_valid),
   .rsp_last_of_run (rsp_chan.last_of_run)
);
